@@ design/wlh_pkg.sv @@
// Shared constants for the word length histogram block.
package wlh_pkg;

    // Character codes that end a word.
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    // Fixed field widths.
    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 16;
    localparam int LENF_W   = 4;
    localparam int BARF_W   = 4;

    // Largest bar height the output field can carry.
    localparam logic [BARF_W-1:0] BAR_MAX = 4'd15;

    // Stream data widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 40;

endpackage

@@ design/wlh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module wlh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ design/word_length_histogram.sv @@
// Word length histogram: character stream in, per-length report out on end of input.
// A word-ending character that fills a bin starts a bin read-modify-write; s_tready is low meanwhile.
// End item: flush the word in progress, scan all bins for the max, then per bin, on the one RAM port,
//   read, multiply, divide to BAR_W bits (BAR_W = bits of BAR_LEVELS), emit when output is free.
// Reset (aresetn low, synchronous) empties all bins, the long word count and the word in progress;
//   bins are tracked by per-entry valid flops, so no clearing pass is needed.
module word_length_histogram #(
    parameter int MAX_WORD_LEN = 11,
    parameter int BAR_LEVELS   = 15
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input characters
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wlh_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] char_code
    input  logic                            s_tlast,   // end_of_input
    // Report results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] bin_length, [19:4] bin_count, [23:20] bar_height, [39:24] long_word_count
    output logic [wlh_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast    // last result of the report
);

    localparam int NUM_BINS = MAX_WORD_LEN - 1;
    localparam int IDX_W    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int IDX1_W   = IDX_W + 1;
    localparam int LEN_W    = $clog2(MAX_WORD_LEN + 1);
    localparam int BAR_W    = $clog2(BAR_LEVELS + 1);
    localparam int STEP_W   = (BAR_W > 1) ? $clog2(BAR_W) : 1;
    localparam int QX_W     = (BAR_W > wlh_pkg::BARF_W) ? BAR_W : wlh_pkg::BARF_W;
    localparam int PROD_W   = wlh_pkg::COUNT_W + BAR_W;
    localparam int COUNT_W  = wlh_pkg::COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,     // taking characters
        ST_INC,      // bin read data back, write bumped count
        ST_MAX_RD,   // read bin for max scan
        ST_MAX_CMP,  // compare against running max
        ST_REP_RD,   // read bin for report
        ST_REP_MUL,  // count * BAR_LEVELS
        ST_REP_DIV,  // one quotient bit per cycle
        ST_REP_OUT   // hand result to output register
    } state_t;

    state_t               state_reg, state_next;
    logic [LEN_W-1:0]     cur_len_reg, cur_len_next;
    logic [COUNT_W-1:0]   ovf_reg, ovf_next;
    logic [NUM_BINS-1:0]  valid_reg, valid_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 end_pend_reg, end_pend_next;
    logic [COUNT_W-1:0]   max_reg, max_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [PROD_W-1:0]    div_reg, div_next;
    logic [BAR_W-1:0]     q_reg, q_next;
    logic [STEP_W-1:0]    step_reg, step_next;

    // Output register
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [wlh_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tlast_reg, m_tlast_next;

    // Bin RAM port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [COUNT_W-1:0] ram_rdata;
    logic [COUNT_W-1:0] bin_val;

    logic [wlh_pkg::CHAR_W-1:0] char_code;
    logic                       in_acc;
    logic                       is_sep;
    logic [IDX_W-1:0]           flush_idx;
    logic                       last_idx;
    logic                       out_free;
    logic                       div_ge;
    logic [QX_W-1:0]            q_ext;
    logic [wlh_pkg::BARF_W-1:0] bar;
    logic [IDX1_W-1:0]          len_wide;
    logic [wlh_pkg::LENF_W-1:0] bin_length;

    assign char_code = s_tdata[wlh_pkg::CHAR_W-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign is_sep    = (char_code == wlh_pkg::CHAR_SPACE) || (char_code == wlh_pkg::CHAR_NL)
                    || (char_code == wlh_pkg::CHAR_TAB);
    assign flush_idx = IDX_W'(cur_len_reg - LEN_W'(1));
    assign last_idx  = (idx_reg == IDX_W'(NUM_BINS - 1));
    assign out_free  = !m_tvalid_reg || m_tready;

    // Entries never written since the last clear read as zero.
    assign bin_val   = valid_reg[idx_reg] ? ram_rdata : '0;

    // Shared compare/subtract for the restoring divide.
    assign div_ge    = (rem_reg >= div_reg);

    // Bar height, forced to zero for an empty histogram, clipped to the field.
    assign q_ext = QX_W'(q_reg);
    always_comb begin
        if (max_reg == '0) begin
            bar = '0;
        end else if (q_ext > QX_W'(wlh_pkg::BAR_MAX)) begin
            bar = wlh_pkg::BAR_MAX;
        end else begin
            bar = q_ext[wlh_pkg::BARF_W-1:0];
        end
    end

    assign len_wide   = IDX1_W'(idx_reg) + IDX1_W'(1);
    assign bin_length = wlh_pkg::LENF_W'(len_wide);

    assign ram_raddr = (state_reg == ST_IDLE) ? flush_idx : idx_reg;
    assign ram_waddr = idx_reg;
    assign ram_wdata = (bin_val == '1) ? bin_val : bin_val + COUNT_W'(1);
    assign ram_we    = (state_reg == ST_INC);

    wlh_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        cur_len_next  = cur_len_reg;
        ovf_next      = ovf_reg;
        valid_next    = valid_reg;
        idx_next      = idx_reg;
        end_pend_next = end_pend_reg;
        max_next      = max_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        div_next      = div_reg;
        q_next        = q_reg;
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        // Output handshake retires the held transaction.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tlast || is_sep) begin
                        cur_len_next  = '0;
                        end_pend_next = s_tlast;
                        max_next      = '0;
                        if (cur_len_reg != '0 && cur_len_reg < LEN_W'(MAX_WORD_LEN)) begin
                            // Finished word lands in a bin: read-modify-write.
                            idx_next   = flush_idx;
                            state_next = ST_INC;
                        end else begin
                            if (cur_len_reg != '0 && ovf_reg != '1) begin
                                ovf_next = ovf_reg + COUNT_W'(1);
                            end
                            idx_next   = '0;
                            state_next = s_tlast ? ST_MAX_RD : ST_IDLE;
                        end
                    end else if (cur_len_reg == '0) begin
                        cur_len_next = LEN_W'(1);
                    end else if (cur_len_reg < LEN_W'(MAX_WORD_LEN)) begin
                        cur_len_next = cur_len_reg + LEN_W'(1);
                    end
                end
            end
            ST_INC: begin
                valid_next[idx_reg] = 1'b1;
                idx_next            = '0;
                state_next          = end_pend_reg ? ST_MAX_RD : ST_IDLE;
            end
            ST_MAX_RD: begin
                state_next = ST_MAX_CMP;
            end
            ST_MAX_CMP: begin
                if (bin_val > max_reg) begin
                    max_next = bin_val;
                end
                if (last_idx) begin
                    idx_next   = '0;
                    state_next = ST_REP_RD;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_MAX_RD;
                end
            end
            ST_REP_RD: begin
                state_next = ST_REP_MUL;
            end
            ST_REP_MUL: begin
                cnt_next   = bin_val;
                rem_next   = PROD_W'(bin_val) * PROD_W'(BAR_LEVELS);
                div_next   = PROD_W'(max_reg) << (BAR_W - 1);
                q_next     = '0;
                step_next  = STEP_W'(BAR_W - 1);
                state_next = ST_REP_DIV;
            end
            ST_REP_DIV: begin
                if (div_ge) begin
                    rem_next = rem_reg - div_reg;
                end
                q_next   = BAR_W'({q_reg, div_ge});
                div_next = div_reg >> 1;
                if (step_reg == '0) begin
                    state_next = ST_REP_OUT;
                end else begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_REP_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {ovf_reg, bar, cnt_reg, bin_length};
                    m_tlast_next  = last_idx;
                    if (last_idx) begin
                        // Report done: empty the histogram.
                        valid_next    = '0;
                        ovf_next      = '0;
                        end_pend_next = 1'b0;
                        idx_next      = '0;
                        state_next    = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_REP_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_len_reg  <= '0;
            ovf_reg      <= '0;
            valid_reg    <= '0;
            idx_reg      <= '0;
            end_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_len_reg  <= cur_len_next;
            ovf_reg      <= ovf_next;
            valid_reg    <= valid_next;
            idx_reg      <= idx_next;
            end_pend_reg <= end_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        max_reg     <= max_next;
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        q_reg       <= q_next;
        step_reg    <= step_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
